// File: rtl/bcst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcst_pkg
// Shared constants and types of the trapezoid speed estimator.
// ----------------------------------------------------------------------------
package bcst_pkg;

    // Default width of times, counts and speeds
    localparam int unsigned VALUE_BITS_DEF = 48;

    // Twice the number of microseconds in a second, and its width
    localparam int unsigned SCALE      = 2000000;
    localparam int unsigned SCALE_BITS = 21;

    // Status handed from the serial divider to the sequencer
    typedef struct packed {
        logic done;
        logic over;
    } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/bcst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcst_div
// Bit-serial restoring divider: one quotient bit per cycle. Keeps the low
// VALUE_BITS+1 quotient bits and flags any quotient bit above them.
// ----------------------------------------------------------------------------
module bcst_div #(
    parameter int unsigned VALUE_BITS = bcst_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                             aclk,
    input  wire logic                                             aresetn,
    input  wire logic                                             start,
    input  wire logic [VALUE_BITS+bcst_pkg::SCALE_BITS-1:0]       numer,
    input  wire logic [VALUE_BITS-1:0]                            denom,
    output logic      [VALUE_BITS:0]                              quot,
    output bcst_pkg::div_stat_t                                   stat
);

    localparam int unsigned NB = VALUE_BITS + bcst_pkg::SCALE_BITS;
    localparam int unsigned CW = $clog2(NB + 1);

    logic [NB-1:0]         num_reg;
    logic [VALUE_BITS-1:0] den_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS:0]   quot_reg;
    logic                  over_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS+1:0] diff;
    logic                  fits;

    assign trial = {rem_reg, num_reg[NB-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[VALUE_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
                num_reg  <= numer;
                den_reg  <= denom;
                rem_reg  <= '0;
                quot_reg <= '0;
                over_reg <= 1'b0;
            end else if (busy_reg) begin
                num_reg  <= {num_reg[NB-2:0], 1'b0};
                rem_reg  <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
                quot_reg <= {quot_reg[VALUE_BITS-1:0], fits};
                over_reg <= over_reg | quot_reg[VALUE_BITS];
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.done = done_reg;
    assign stat.over = over_reg;

endmodule
`default_nettype wire

// File: rtl/byte_count_to_speed_trapezoid_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_count_to_speed_trapezoid_unit
// Trapezoid speed estimator over (time, cumulative byte count) samples.
// ----------------------------------------------------------------------------
// Each sample whose time advances and whose count does not fall yields one
// item: the new speed in bytes per second and the time it holds from; other
// samples are dropped with no item. A single bit-serial divider produces one
// quotient bit per cycle. A sample takes one division, or two when the speed
// falls to zero and the second gives the time of the drop. The finished item
// waits in an output register, and the next sample is taken while it waits;
// a further finished item holds until that register is free.
// ----------------------------------------------------------------------------
module byte_count_to_speed_trapezoid_unit #(
    parameter int unsigned VALUE_BITS = bcst_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_sample_time_us,
    input  wire logic [VALUE_BITS-1:0] s_total_bytes,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [VALUE_BITS-1:0] m_rate_bytes_per_s,
    output logic      [VALUE_BITS-1:0] m_rate_time_us
);

    localparam int unsigned NB = VALUE_BITS + bcst_pkg::SCALE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [VALUE_BITS-1:0] prev_time_reg;
    logic [VALUE_BITS-1:0] prev_total_reg;
    logic [VALUE_BITS-1:0] prev_rate_reg;
    logic [VALUE_BITS-1:0] time_reg;
    logic [VALUE_BITS-1:0] total_reg;
    logic [VALUE_BITS-1:0] delta_reg;
    logic [VALUE_BITS-1:0] den_reg;
    logic [NB-1:0]         numer_reg;
    logic                  start_reg;
    logic [VALUE_BITS-1:0] rate_res_reg;
    logic [VALUE_BITS-1:0] when_res_reg;
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_rate_reg;
    logic [VALUE_BITS-1:0] m_time_reg;

    logic [VALUE_BITS:0]   quot;
    bcst_pkg::div_stat_t   dstat;
    logic [VALUE_BITS:0]   rate_diff;
    logic                  rate_ge;
    logic [VALUE_BITS+1:0] when_sum;
    logic                  drop;
    logic                  out_free;

    bcst_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start_reg),
        .numer  (numer_reg),
        .denom  (den_reg),
        .quot   (quot),
        .stat   (dstat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign drop      = (s_sample_time_us <= prev_time_reg) ||
                       (s_total_bytes < prev_total_reg);
    assign rate_ge   = dstat.over || (quot >= {1'b0, prev_rate_reg});
    assign rate_diff = quot - {1'b0, prev_rate_reg};
    assign when_sum  = {1'b0, quot} + {2'b00, prev_time_reg};
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_time_reg  <= '0;
            prev_total_reg <= '0;
            prev_rate_reg  <= '0;
            start_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            start_reg <= (state_reg == ST_PREP) ||
                         ((state_reg == ST_DIV1) && dstat.done && !rate_ge);
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && !drop) begin
                        time_reg  <= s_sample_time_us;
                        total_reg <= s_total_bytes;
                        delta_reg <= s_total_bytes - prev_total_reg;
                        den_reg   <= s_sample_time_us - prev_time_reg;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    numer_reg <= NB'(delta_reg) * NB'(bcst_pkg::SCALE);
                    state_reg <= ST_DIV1;
                end
                ST_DIV1: begin
                    if (dstat.done) begin
                        if (rate_ge) begin
                            rate_res_reg <= (dstat.over || rate_diff[VALUE_BITS]) ?
                                            '1 : rate_diff[VALUE_BITS-1:0];
                            when_res_reg <= time_reg;
                            state_reg    <= ST_OUT;
                        end else begin
                            // speed falls to zero before the sample
                            den_reg   <= prev_rate_reg;
                            state_reg <= ST_DIV2;
                        end
                    end
                end
                ST_DIV2: begin
                    if (dstat.done) begin
                        rate_res_reg <= '0;
                        when_res_reg <= (dstat.over || (|when_sum[VALUE_BITS+1:VALUE_BITS])) ?
                                        '1 : when_sum[VALUE_BITS-1:0];
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_rate_reg     <= rate_res_reg;
                        m_time_reg     <= when_res_reg;
                        prev_rate_reg  <= rate_res_reg;
                        prev_time_reg  <= time_reg;
                        prev_total_reg <= total_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_rate_bytes_per_s = m_rate_reg;
    assign m_rate_time_us     = m_time_reg;

endmodule
`default_nettype wire
